// ===== src/mpk_pkg.sv =====
// Shared types and constants for the MessagePack token decoder.
// Token type codes, parse phase codes, result word struct, header length lookup.
// No dependencies.
package mpk_pkg;

  localparam logic [3:0] TOK_NIL   = 4'd0;
  localparam logic [3:0] TOK_BOOL  = 4'd1;
  localparam logic [3:0] TOK_UINT  = 4'd2;
  localparam logic [3:0] TOK_INT   = 4'd3;
  localparam logic [3:0] TOK_F32   = 4'd4;
  localparam logic [3:0] TOK_F64   = 4'd5;
  localparam logic [3:0] TOK_STR   = 4'd6;
  localparam logic [3:0] TOK_BIN   = 4'd7;
  localparam logic [3:0] TOK_ARRAY = 4'd8;
  localparam logic [3:0] TOK_MAP   = 4'd9;
  localparam logic [3:0] TOK_END   = 4'd10;
  localparam logic [3:0] TOK_ERR   = 4'd11;
  localparam logic [3:0] TOK_PAY   = 4'd12;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;

  typedef struct packed {
    logic [3:0]  token_type;
    logic [63:0] token_value;
    logic [7:0]  payload_byte;
    logic        payload_end;
  } tok_t;

  typedef struct packed {
    logic valid;
    logic end_pend;
  } out_stat_t;

  function automatic logic [3:0] header_size(input logic [7:0] tag);
    logic [3:0] hs;
    case (tag) inside
      8'hc4, 8'hcc, 8'hd0, 8'hd9: hs = 4'd1;
      8'hc5, 8'hcd, 8'hd1, 8'hda, 8'hdc, 8'hde: hs = 4'd2;
      8'hc6, 8'hca, 8'hce, 8'hd2, 8'hdb, 8'hdd, 8'hdf: hs = 4'd4;
      8'hcb, 8'hcf, 8'hd3: hs = 4'd8;
      default: hs = 4'd0;
    endcase
    return hs;
  endfunction

endpackage

// ===== src/mpk_decode.sv =====
// Parse state registers and the tag/header/payload decode for one byte.
// Depends on mpk_pkg.
module mpk_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    dat_byte,
  input  logic          dat_last,
  input  logic          advance,
  output logic          prim_valid,
  output mpk_pkg::tok_t prim
);

  logic [1:0]  ph_r, ph_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [3:0]  hl_r, hl_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] pl_r, pl_nxt;

  logic [63:0] acc_sh;
  logic [3:0]  hl_dec;
  logic [3:0]  hs;
  logic        raw_go;
  logic [3:0]  raw_type;
  logic [31:0] raw_len;

  always_comb begin
    ph_nxt     = ph_r;
    tag_nxt    = tag_r;
    hl_nxt     = hl_r;
    acc_nxt    = acc_r;
    pl_nxt     = pl_r;
    prim_valid = 1'b0;
    prim       = '0;
    raw_go     = 1'b0;
    raw_type   = mpk_pkg::TOK_STR;
    raw_len    = 32'd0;
    acc_sh     = {acc_r[55:0], dat_byte};
    hl_dec     = hl_r - 4'd1;
    hs         = mpk_pkg::header_size(dat_byte);

    if (ph_r == mpk_pkg::PH_PAY && pl_r != 32'd0) begin
      prim_valid = 1'b1;
      if (dat_last && pl_r > 32'd1) begin
        prim.token_type = mpk_pkg::TOK_ERR;
        ph_nxt          = mpk_pkg::PH_IDLE;
      end else begin
        prim.token_type   = mpk_pkg::TOK_PAY;
        prim.payload_byte = dat_byte;
        prim.payload_end  = (pl_r == 32'd1);
        pl_nxt            = pl_r - 32'd1;
        if (pl_r == 32'd1) ph_nxt = mpk_pkg::PH_IDLE;
      end
    end else if (ph_r == mpk_pkg::PH_HEAD && hl_r != 4'd0) begin
      acc_nxt = acc_sh;
      hl_nxt  = hl_dec;
      if (hl_dec == 4'd0) begin
        ph_nxt     = mpk_pkg::PH_IDLE;
        prim_valid = 1'b1;
        case (tag_r) inside
          8'hc4, 8'hc5, 8'hc6: begin
            raw_go   = 1'b1;
            raw_type = mpk_pkg::TOK_BIN;
            raw_len  = acc_sh[31:0];
          end
          8'hd9, 8'hda, 8'hdb: begin
            raw_go   = 1'b1;
            raw_type = mpk_pkg::TOK_STR;
            raw_len  = acc_sh[31:0];
          end
          8'hca: begin
            prim.token_type  = mpk_pkg::TOK_F32;
            prim.token_value = {32'd0, acc_sh[31:0]};
          end
          8'hcb: begin
            prim.token_type  = mpk_pkg::TOK_F64;
            prim.token_value = acc_sh;
          end
          8'hcc, 8'hcd, 8'hce, 8'hcf: begin
            prim.token_type  = mpk_pkg::TOK_UINT;
            prim.token_value = acc_sh;
          end
          8'hd0: begin
            prim.token_type  = mpk_pkg::TOK_INT;
            prim.token_value = {{56{acc_sh[7]}}, acc_sh[7:0]};
          end
          8'hd1: begin
            prim.token_type  = mpk_pkg::TOK_INT;
            prim.token_value = {{48{acc_sh[15]}}, acc_sh[15:0]};
          end
          8'hd2: begin
            prim.token_type  = mpk_pkg::TOK_INT;
            prim.token_value = {{32{acc_sh[31]}}, acc_sh[31:0]};
          end
          8'hd3: begin
            prim.token_type  = mpk_pkg::TOK_INT;
            prim.token_value = acc_sh;
          end
          8'hdc, 8'hdd: begin
            prim.token_type  = mpk_pkg::TOK_ARRAY;
            prim.token_value = {32'd0, acc_sh[31:0]};
          end
          8'hde, 8'hdf: begin
            prim.token_type  = mpk_pkg::TOK_MAP;
            prim.token_value = {32'd0, acc_sh[31:0]};
          end
          default: prim.token_type = mpk_pkg::TOK_ERR;
        endcase
      end else if (dat_last) begin
        prim_valid      = 1'b1;
        prim.token_type = mpk_pkg::TOK_ERR;
        ph_nxt          = mpk_pkg::PH_IDLE;
      end
    end else begin
      ph_nxt     = mpk_pkg::PH_IDLE;
      prim_valid = 1'b1;
      if (dat_byte <= 8'h7f) begin
        prim.token_type  = mpk_pkg::TOK_UINT;
        prim.token_value = {56'd0, dat_byte};
      end else if (dat_byte >= 8'he0) begin
        prim.token_type  = mpk_pkg::TOK_INT;
        prim.token_value = {{56{1'b1}}, dat_byte};
      end else if ((dat_byte & 8'hf0) == 8'h80) begin
        prim.token_type  = mpk_pkg::TOK_MAP;
        prim.token_value = {60'd0, dat_byte[3:0]};
      end else if ((dat_byte & 8'hf0) == 8'h90) begin
        prim.token_type  = mpk_pkg::TOK_ARRAY;
        prim.token_value = {60'd0, dat_byte[3:0]};
      end else if ((dat_byte & 8'he0) == 8'ha0) begin
        raw_go   = 1'b1;
        raw_type = mpk_pkg::TOK_STR;
        raw_len  = {27'd0, dat_byte[4:0]};
      end else if (dat_byte == 8'hc0) begin
        prim.token_type = mpk_pkg::TOK_NIL;
      end else if (dat_byte == 8'hc2 || dat_byte == 8'hc3) begin
        prim.token_type  = mpk_pkg::TOK_BOOL;
        prim.token_value = {63'd0, dat_byte[0]};
      end else if (hs == 4'd0 || dat_last) begin
        prim.token_type = mpk_pkg::TOK_ERR;
      end else begin
        prim_valid = 1'b0;
        tag_nxt    = dat_byte;
        hl_nxt     = hs;
        acc_nxt    = 64'd0;
        ph_nxt     = mpk_pkg::PH_HEAD;
      end
    end

    if (raw_go) begin
      if (raw_len == 32'd0) begin
        prim.token_type  = raw_type;
        prim.token_value = 64'd0;
      end else if (dat_last) begin
        prim.token_type = mpk_pkg::TOK_ERR;
      end else begin
        prim.token_type  = raw_type;
        prim.token_value = {32'd0, raw_len};
        pl_nxt           = raw_len;
        ph_nxt           = mpk_pkg::PH_PAY;
      end
    end

    if (dat_last) begin
      ph_nxt = mpk_pkg::PH_IDLE;
      hl_nxt = 4'd0;
      pl_nxt = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= mpk_pkg::PH_IDLE;
      tag_r <= 8'd0;
      hl_r  <= 4'd0;
      acc_r <= 64'd0;
      pl_r  <= 32'd0;
    end else if (advance) begin
      ph_r  <= ph_nxt;
      tag_r <= tag_nxt;
      hl_r  <= hl_nxt;
      acc_r <= acc_nxt;
      pl_r  <= pl_nxt;
    end
  end

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && dat_last |=> ph_r == mpk_pkg::PH_IDLE && hl_r == 4'd0 && pl_r == 32'd0)
    else $error("parse state not cleared after buffer end");

  a_head_len: assert property (@(posedge clk) disable iff (!rst_n)
    hl_r <= 4'd8)
    else $error("header count out of range");

  a_pay_end: assert property (@(posedge clk) disable iff (!rst_n)
    prim_valid && prim.payload_end |-> prim.token_type == mpk_pkg::TOK_PAY && pl_r == 32'd1)
    else $error("payload end on wrong byte");

endmodule

// ===== src/mpk_out.sv =====
// Result register with a pending end-of-buffer slot.
// Depends on mpk_pkg.
module mpk_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              prim_valid,
  input  mpk_pkg::tok_t     prim,
  input  logic              dat_last,
  input  logic              out_stall,
  output mpk_pkg::out_stat_t stat,
  output logic              out_valid,
  output mpk_pkg::tok_t     res,
  output logic              out_run_last
);

  logic          valid_r, valid_nxt;
  logic          pend_r, pend_nxt;
  mpk_pkg::tok_t res_r, res_nxt;
  logic          rl_r, rl_nxt;
  logic          out_free;
  mpk_pkg::tok_t end_tok;

  always_comb begin
    end_tok            = '0;
    end_tok.token_type = mpk_pkg::TOK_END;
    out_free  = !valid_r || !out_stall;
    valid_nxt = valid_r;
    pend_nxt  = pend_r;
    res_nxt   = res_r;
    rl_nxt    = rl_r;
    if (out_free) begin
      if (pend_r) begin
        valid_nxt = 1'b1;
        pend_nxt  = 1'b0;
        res_nxt   = end_tok;
        rl_nxt    = 1'b1;
      end else if (advance && prim_valid) begin
        valid_nxt = 1'b1;
        pend_nxt  = dat_last;
        res_nxt   = prim;
        rl_nxt    = !dat_last;
      end else if (advance && dat_last) begin
        valid_nxt = 1'b1;
        res_nxt   = end_tok;
        rl_nxt    = 1'b1;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    rl_r  <= rl_nxt;
  end

  assign out_valid     = valid_r;
  assign res           = res_r;
  assign out_run_last  = rl_r;
  assign stat.valid    = valid_r;
  assign stat.end_pend = pend_r;

  a_pend_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> valid_r && !rl_r)
    else $error("end pending without a held result");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && res_r.token_type == mpk_pkg::TOK_END |-> rl_r)
    else $error("end token not marked last");

endmodule

// ===== src/messagepack_token_decoder.sv =====
// Top level of the MessagePack token decoder: input register and glue.
// Depends on mpk_pkg, mpk_decode and mpk_out.
//
//   channel  direction  handshake            word
//   in_      input      in_valid / in_stall   in_byte, in_buffer_last
//   out_     output     out_valid / out_stall token type, value, payload byte/end, run_last
//
// One byte a cycle when not stalled: input register, then decode into the result register.
// A byte that ends a buffer with a token gives two words; the input stage holds while the end word is pending.
// Synchronous active-low reset clears parse state and both valid flags.
// out_stall holds the result register; in_stall rises once the input register cannot drain.
module messagepack_token_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_buffer_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_type,
  output logic [63:0] out_token_value,
  output logic [7:0]  out_payload_byte,
  output logic        out_payload_end,
  output logic        out_run_last
);

  logic               s1_valid_r;
  logic [7:0]         s1_byte_r;
  logic               s1_last_r;
  logic               advance;
  logic               prim_valid;
  mpk_pkg::tok_t      prim;
  mpk_pkg::tok_t      res;
  mpk_pkg::out_stat_t stat;

  assign advance  = s1_valid_r && (!stat.valid || !out_stall) && !stat.end_pend;
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_buffer_last;
    end
  end

  mpk_decode u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .dat_byte   (s1_byte_r),
    .dat_last   (s1_last_r),
    .advance    (advance),
    .prim_valid (prim_valid),
    .prim       (prim)
  );

  mpk_out u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .prim_valid   (prim_valid),
    .prim         (prim),
    .dat_last     (s1_last_r),
    .out_stall    (out_stall),
    .stat         (stat),
    .out_valid    (out_valid),
    .res          (res),
    .out_run_last (out_run_last)
  );

  assign out_token_type   = res.token_type;
  assign out_token_value  = res.token_value;
  assign out_payload_byte = res.payload_byte;
  assign out_payload_end  = res.payload_end;

  a_no_adv_pend: assert property (@(posedge clk) disable iff (!rst_n)
    stat.end_pend |-> !advance)
    else $error("byte consumed while end word pending");

endmodule
